// ===== sv/irtl_pkg.sv =====
// ----------------------------------------------------------------------------
// irtl_pkg
// Shared types and constants for the IPv4 range table lookup block.
// ----------------------------------------------------------------------------
package irtl_pkg;

    localparam int TABLE_ENTRIES_DEF = 4096;

    localparam int ADDR_W = 32;
    localparam int TAG_W  = 31;

    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_APPEND = 2'd1,
        MODE_LOOKUP = 2'd2,
        MODE_NOP    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_ORDER     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_CHECK,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0] low;
        logic [ADDR_W-1:0] high;
        logic [TAG_W-1:0]  tag;
    } t_entry;

endpackage

// ===== sv/ip_range_table_lookup.sv =====
// ----------------------------------------------------------------------------
// ip_range_table_lookup
// Table of IPv4 address ranges with append, clear and binary-search lookup.
// ----------------------------------------------------------------------------
// The block keeps up to TABLE_ENTRIES ranges (low bound, high bound, tag) in
// one single-port-write, registered-read memory. Items arrive one beat at a
// time on the input channel and each gives exactly one result beat. A clear
// or an append is settled in the cycle it is accepted; its result then waits
// in S_RESULT until the output register is free, and the input is free
// again once the result moves there. A lookup binary-searches the table
// with one memory read per probe: at most ceil(log2(count+1)) probes, then
// one read of the candidate entry for the low-bound check (skipped when the
// address lies above every high bound; an empty table is not searched at
// all), then S_RESULT. The single memory read port allows one read at a
// time. One item is processed at a time; the result sits in an output
// register, so a finished result may wait for the consumer while the next
// item is taken. Appends must come in non-decreasing order of high bound;
// an out-of-order append is dropped with status "out of order", an append
// to a full table is dropped with status "table full" (full takes
// precedence). Entries beyond the fill count are never read, so the memory
// needs no clearing pass after reset.
// ----------------------------------------------------------------------------
module ip_range_table_lookup
    import irtl_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input channel
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_mode,
    input  logic [ADDR_W-1:0] i_range_low,
    input  logic [ADDR_W-1:0] i_range_high,
    input  logic [TAG_W-1:0]  i_range_tag,
    input  logic [ADDR_W-1:0] i_lookup_address,
    // result channel
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_status,
    output logic [TAG_W-1:0]  o_found_tag
);

    // index width addresses the memory; count width can also hold the depth
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_ENTRIES);

    // range memory
    t_entry mem [TABLE_ENTRIES];
    t_entry r_rd;
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    t_entry           wr_data;

    // control and search state
    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [ADDR_W-1:0] r_last_high, n_last_high;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [CNT_W-1:0]  r_lo, n_lo;
    logic [CNT_W-1:0]  r_hi, n_hi;
    logic [CNT_W-1:0]  r_mid, n_mid;
    t_status           r_res_status, n_res_status;
    logic [TAG_W-1:0]  r_res_tag, n_res_tag;

    // output register
    logic              r_out_valid, n_out_valid;
    t_status           r_out_status, n_out_status;
    logic [TAG_W-1:0]  r_out_tag, n_out_tag;

    // search step planning from a candidate (lo, hi) pair
    logic [CNT_W-1:0] plan_lo;
    logic [CNT_W-1:0] plan_hi;
    logic [CNT_W:0]   plan_sum;
    logic [CNT_W-1:0] plan_mid;
    logic             in_beat;

    assign o_ready  = (r_state == S_IDLE);
    assign in_beat  = i_valid && o_ready;
    assign plan_sum = {1'b0, plan_lo} + {1'b0, plan_hi};
    assign plan_mid = plan_sum[CNT_W:1];

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_last_high  = r_last_high;
        n_addr       = r_addr;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_mid        = r_mid;
        n_res_status = r_res_status;
        n_res_tag    = r_res_tag;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_tag    = r_out_tag;
        rd_en        = 1'b0;
        rd_idx       = plan_mid[IDX_W-1:0];
        wr_en        = 1'b0;
        wr_idx       = r_count[IDX_W-1:0];
        wr_data      = '{low: i_range_low, high: i_range_high, tag: i_range_tag};
        plan_lo      = r_lo;
        plan_hi      = r_hi;

        // drop the held result once the consumer takes it
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                plan_lo = '0;
                plan_hi = r_count;
                if (in_beat) begin
                    n_res_status = ST_OK;
                    n_res_tag    = '0;
                    n_state      = S_RESULT;
                    unique case (t_mode'(i_mode))
                        MODE_CLEAR: begin
                            n_count = '0;
                        end
                        MODE_APPEND: begin
                            if (r_count == FULL_COUNT) begin
                                n_res_status = ST_FULL;
                            end else if (r_count != '0 && i_range_high < r_last_high) begin
                                n_res_status = ST_ORDER;
                            end else begin
                                wr_en       = 1'b1;
                                n_count     = r_count + 1'b1;
                                n_last_high = i_range_high;
                            end
                        end
                        MODE_LOOKUP: begin
                            n_addr = i_lookup_address;
                            n_lo   = '0;
                            n_hi   = r_count;
                            // empty table: nothing to search
                            if (r_count == '0) begin
                                n_res_status = ST_NOT_FOUND;
                            end else begin
                                rd_en   = 1'b1;
                                n_mid   = plan_mid;
                                n_state = S_PROBE;
                            end
                        end
                        MODE_NOP: begin
                            n_res_status = ST_OK;
                        end
                        default: begin
                            n_res_status = ST_OK;
                        end
                    endcase
                end
            end

            S_PROBE: begin
                // narrow the window on the high bound just read
                if (r_rd.high < r_addr) begin
                    plan_lo = r_mid + 1'b1;
                    plan_hi = r_hi;
                end else begin
                    plan_lo = r_lo;
                    plan_hi = r_mid;
                end
                n_lo = plan_lo;
                n_hi = plan_hi;
                if (plan_lo < plan_hi) begin
                    rd_en  = 1'b1;
                    n_mid  = plan_mid;
                end else if (plan_lo < r_count) begin
                    // fetch the candidate for the low-bound check
                    rd_en   = 1'b1;
                    rd_idx  = plan_lo[IDX_W-1:0];
                    n_state = S_CHECK;
                end else begin
                    n_res_status = ST_NOT_FOUND;
                    n_res_tag    = '0;
                    n_state      = S_RESULT;
                end
            end

            S_CHECK: begin
                if (r_rd.low > r_addr) begin
                    n_res_status = ST_NOT_FOUND;
                    n_res_tag    = '0;
                end else begin
                    n_res_status = ST_OK;
                    n_res_tag    = r_rd.tag;
                end
                n_state = S_RESULT;
            end

            S_RESULT: begin
                // hold until the output register is free
                if (!r_out_valid || i_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_tag    = r_res_tag;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= mem[rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last_high  <= n_last_high;
        r_addr       <= n_addr;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_mid        <= n_mid;
        r_res_status <= n_res_status;
        r_res_tag    <= n_res_tag;
        r_out_status <= n_out_status;
        r_out_tag    <= n_out_tag;
    end

    assign o_valid     = r_out_valid;
    assign o_status    = r_out_status;
    assign o_found_tag = r_out_tag;

endmodule

// ===== sv/irtl_checker.sv =====
// ----------------------------------------------------------------------------
// irtl_checker
// Port-level checks for the IPv4 range table lookup block.
// ----------------------------------------------------------------------------
module irtl_checker
    import irtl_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_ready,
    input logic              o_valid,
    input logic              i_ready,
    input logic [1:0]        o_status,
    input logic [TAG_W-1:0]  o_found_tag
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_status) && $stable(o_found_tag)))
        else $error("result beat changed while stalled");

    // tag is zero unless the status says found
    a_tag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_found_tag == '0))
        else $error("non-zero tag on a miss or rejected append");

    // one item in flight: ready drops after each accepted beat
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second item taken while one is in progress");

    // no result straight out of reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat shown after reset");

endmodule

bind ip_range_table_lookup irtl_checker u_irtl_checker (.*);
